/* hw/rtl/hgct_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the grid claim table.
package hgct_pkg;

   localparam int SLOT_CAPACITY = 256;
   localparam int TABLE_ENTRIES = 1024;

   localparam int TABLE_IDX_W = $clog2(TABLE_ENTRIES);
   localparam int SLOT_IDX_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int ENTRY_W     = SLOT_IDX_W + 1;
   localparam int POS_W       = 16;
   localparam int KEY_W       = 3 * POS_W;
   localparam int SLOT_W      = 8;
   localparam int DEMAND_W    = 16;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   localparam logic [DEMAND_W-1:0]    CURSOR_MAX = 16'hFFFF;
   localparam logic [TABLE_IDX_W-1:0] IDX_MASK   = TABLE_IDX_W'(TABLE_ENTRIES - 1);

   // hash multipliers and offset
   localparam logic [31:0] HASH_KX  = 32'd1597334673;
   localparam logic [31:0] HASH_KY  = 32'd3812015801;
   localparam logic [31:0] HASH_KZ  = 32'd2798796415;
   localparam logic [31:0] HASH_K1  = 32'd747796405;
   localparam logic [31:0] HASH_C1  = 32'd2891336453;
   localparam logic [31:0] HASH_K2  = 32'd277803737;

   typedef enum logic {
      OP_CLAIM = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_FOUND   = 2'd0,
      ST_NEW     = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef struct packed {
      logic load;         // capture the request word
      logic start_clear;  // zero cursor and sweep counter, stage a cleared response
      logic sweep;        // write one empty entry, step the sweep counter
      logic idx_load;     // take the start entry from the hash pipe
      logic ent_eval;     // act on the entry read back
      logic pos_eval;     // act on the slot position read back
      logic rsp_load;     // move the staged result to the output register
   } hgct_cmd_type;

   typedef struct packed {
      logic ent_valid;    // entry read back is occupied
      logic pos_match;    // recorded position equals the key
      logic cnt_last;     // counter is at its last entry
   } hgct_stat_type;

endpackage

/* hw/rtl/hgct_ram.sv */
// Generic simple dual-port RAM with registered read.
module hgct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/hgct_ctrl.sv */
// Sequencing state machine of the grid claim table.
module hgct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output hgct_pkg::hgct_cmd_type cmd,
   input  hgct_pkg::hgct_stat_type stat
);
   import hgct_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_CLEAR = 10'b00_0000_0010,
      S_HASH1 = 10'b00_0000_0100,
      S_HASH2 = 10'b00_0000_1000,
      S_HASH3 = 10'b00_0001_0000,
      S_HASH4 = 10'b00_0010_0000,
      S_READ  = 10'b00_0100_0000,
      S_ENTRY = 10'b00_1000_0000,
      S_POS   = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_pend_ff, clr_pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      clr_pend_in  = clr_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (opcode_type'(req_tuser) == OP_CLEAR) begin
                  cmd.start_clear = 1'b1;
                  clr_pend_in     = 1'b1;
                  state_in        = S_CLEAR;
               end else begin
                  state_in = S_HASH1;
               end
            end
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.cnt_last) begin
               clr_pend_in = 1'b0;
               state_in    = clr_pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_HASH1: state_in = S_HASH2;
         S_HASH2: state_in = S_HASH3;
         S_HASH3: state_in = S_HASH4;
         S_HASH4: begin
            cmd.idx_load = 1'b1;
            state_in     = S_READ;
         end
         S_READ: state_in = S_ENTRY;
         S_ENTRY: begin
            cmd.ent_eval = 1'b1;
            state_in     = stat.ent_valid ? S_POS : S_DONE;
         end
         S_POS: begin
            cmd.pos_eval = 1'b1;
            state_in     = (stat.pos_match || stat.cnt_last) ? S_DONE : S_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/hgct_dpath.sv */
// Hash pipe, probe registers, allocation cursor, table memories and response registers.
module hgct_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  hgct_pkg::hgct_cmd_type          cmd,
   output hgct_pkg::hgct_stat_type         stat,
   input  logic [hgct_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic [hgct_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser
);
   import hgct_pkg::*;

   logic [KEY_W-1:0]       key_ff;
   logic [31:0]            px, py, pz;
   logic [31:0]            ha_ff, hb_ff, hc_ff;
   logic [31:0]            hn_ff;
   logic [4:0]             shamt;
   logic [31:0]            ht_ff;
   logic [31:0]            hm, hf;

   logic [TABLE_IDX_W-1:0] idx_ff, idx_in;
   logic [TABLE_IDX_W-1:0] cnt_ff, cnt_in;
   logic [DEMAND_W-1:0]    cursor_ff, cursor_in, cursor_take;
   logic                   alloc_ok;

   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   status_type             res_status_ff, res_status_in;
   logic [DEMAND_W-1:0]    res_demand_ff, res_demand_in;
   logic [SLOT_W-1:0]      out_slot_ff;
   status_type             out_status_ff;
   logic [DEMAND_W-1:0]    out_demand_ff;

   logic                   ent_wr_en;
   logic [TABLE_IDX_W-1:0] ent_wr_addr;
   logic [ENTRY_W-1:0]     ent_wr_data, ent_rd_data;
   logic                   pos_wr_en;
   logic [KEY_W-1:0]       pos_rd_data;
   logic [SLOT_IDX_W-1:0]  ent_slot;

   // hash pipe: three products, mix, variable shift, final product in the index load
   assign px    = {{(32 - POS_W){key_ff[POS_W-1]}}, key_ff[POS_W-1:0]};
   assign py    = {{(32 - POS_W){key_ff[2*POS_W-1]}}, key_ff[2*POS_W-1:POS_W]};
   assign pz    = {{(32 - POS_W){key_ff[3*POS_W-1]}}, key_ff[3*POS_W-1:2*POS_W]};
   assign shamt = {1'b0, hn_ff[31:28]} + 5'd4;
   assign hm    = ht_ff * HASH_K2;
   assign hf    = (hm >> 22) ^ hm;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_tdata[KEY_W-1:0];
      end
      ha_ff <= px * HASH_KX;
      hb_ff <= py * HASH_KY;
      hc_ff <= pz * HASH_KZ;
      hn_ff <= (ha_ff ^ hb_ff ^ hc_ff) * HASH_K1 + HASH_C1;
      ht_ff <= (hn_ff >> shamt) ^ hn_ff;
   end

   assign ent_slot       = ent_rd_data[SLOT_IDX_W-1:0];
   assign stat.ent_valid = ent_rd_data[SLOT_IDX_W];
   assign stat.pos_match = (pos_rd_data == key_ff);
   assign stat.cnt_last  = (cnt_ff == IDX_MASK);

   // cursor keeps counting demand even when no slot is handed out
   assign cursor_take = (cursor_ff != CURSOR_MAX) ? cursor_ff + 16'd1 : cursor_ff;
   assign alloc_ok    = (cursor_ff != CURSOR_MAX) &&
                        ({1'b0, cursor_ff} < 17'(SLOT_CAPACITY));

   always_comb begin
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      cursor_in     = cursor_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_demand_in = res_demand_ff;
      ent_wr_en     = 1'b0;
      ent_wr_addr   = idx_ff;
      ent_wr_data   = {1'b1, cursor_ff[SLOT_IDX_W-1:0]};
      pos_wr_en     = 1'b0;
      if (cmd.start_clear) begin
         cnt_in        = '0;
         cursor_in     = '0;
         res_slot_in   = '0;
         res_status_in = ST_CLEARED;
         res_demand_in = '0;
      end
      if (cmd.sweep) begin
         ent_wr_en   = 1'b1;
         ent_wr_addr = cnt_ff;
         ent_wr_data = '0;
         cnt_in      = cnt_ff + 1'b1;
      end
      if (cmd.idx_load) begin
         idx_in = hf[TABLE_IDX_W-1:0] & IDX_MASK;
         cnt_in = '0;
      end
      if (cmd.ent_eval && !stat.ent_valid) begin
         cursor_in     = cursor_take;
         res_demand_in = cursor_take;
         if (alloc_ok) begin
            ent_wr_en     = 1'b1;
            pos_wr_en     = 1'b1;
            res_slot_in   = cursor_ff[SLOT_W-1:0];
            res_status_in = ST_NEW;
         end else begin
            res_slot_in   = '0;
            res_status_in = ST_FULL;
         end
      end
      if (cmd.pos_eval) begin
         if (stat.pos_match) begin
            res_slot_in   = SLOT_W'({{(32 - SLOT_IDX_W){1'b0}}, ent_slot});
            res_status_in = ST_FOUND;
            res_demand_in = cursor_ff;
         end else if (stat.cnt_last) begin
            // every entry visited: no room anywhere
            cursor_in     = cursor_take;
            res_slot_in   = '0;
            res_status_in = ST_FULL;
            res_demand_in = cursor_take;
         end else begin
            idx_in = (idx_ff + 1'b1) & IDX_MASK;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         cursor_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_demand_ff <= res_demand_in;
      if (cmd.rsp_load) begin
         out_slot_ff   <= res_slot_ff;
         out_status_ff <= res_status_ff;
         out_demand_ff <= res_demand_ff;
      end
   end

   hgct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ent_rd_data)
   );

   hgct_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOT_CAPACITY)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (cursor_ff[SLOT_IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (ent_slot),
      .rd_data (pos_rd_data)
   );

   assign rsp_tdata = {out_demand_ff, out_slot_ff};
   assign rsp_tuser = out_status_ff;

endmodule

/* hw/rtl/hash_grid_claim_table.sv */
// Top level of the grid claim table: linear-probing hash table of 3-D grid positions.
//
//  channel  dir  tdata (low bit up)                     tuser           tlast
//  req_     in   pos_x[15:0] pos_y[31:16] pos_z[47:32]  opcode (1 bit)  -
//  rsp_     out  slot[7:0] demand[23:8]                 status (2 bits) -
//
// One word is worked on at a time. A claim runs from accept through 4 hash stages
// and an entry read; an empty first entry is then allocated and the response staged,
// a match there first needs a slot-position read, and each further entry probed
// adds a probe: each probe is an entry-memory read followed by a slot-position read.
// A clear word sweeps the entry memory one entry a cycle, all TABLE_ENTRIES entries
// (1024), then answers. Reset runs the same sweep with no answer; req_tready stays
// low until it ends. A finished word sits in the output register while the next
// request is accepted; the block only waits on rsp_tready when a second result is due.
module hash_grid_claim_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hgct_pkg::REQ_TDATA_W-1:0] req_tdata,  // pos_x, pos_y, pos_z
   input  logic                            req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hgct_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // slot, demand
   output logic [1:0]                      rsp_tuser   // status
);
   import hgct_pkg::*;

   hgct_cmd_type  cmd;
   hgct_stat_type stat;

   hgct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   hgct_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* test/tb_hash_grid_claim_table.sv */
// Self-checking testbench of the grid claim table: directed rows, then random frames.
`timescale 1ns / 100ps

module tb_hash_grid_claim_table;
   import hgct_pkg::*;

   // request word as it travels: position packed {z, y, x}, x in the low bits
   typedef struct packed {
      opcode_type  op;
      logic [47:0] pos;
   } grid_word_type;

   typedef struct packed {
      logic [7:0]  slot;
      status_type  status;
      logic [15:0] demand;
   } claim_result_type;

   // one row of the directed table; typed rows carry their answer,
   // the others are answered by the predictor
   typedef struct packed {
      grid_word_type    word;
      logic             typed;
      claim_result_type result;
   } stim_row_type;

   // hash constants, kept local to the bench
   localparam logic [31:0] MUL_X    = 32'd1597334673;
   localparam logic [31:0] MUL_Y    = 32'd3812015801;
   localparam logic [31:0] MUL_Z    = 32'd2798796415;
   localparam logic [31:0] MIX_MUL  = 32'd747796405;
   localparam logic [31:0] MIX_ADD  = 32'd2891336453;
   localparam logic [31:0] FOLD_MUL = 32'd277803737;

   localparam logic [15:0] DEMAND_TOP    = 16'hFFFF;
   localparam int          RANDOM_WORDS  = 1630;
   localparam int          POOL_DEPTH    = 1024;
   localparam int          PENDING_DEPTH = 4096;  // one entry per word sent
   localparam int          DIRECTED_MAX  = 32;
   localparam int          TAIL_CYCLES   = 64;
   localparam int          WATCHDOG      = 6000;  // > clear sweep + worst probe chain + stalls
   localparam int          MAX_REPORTS   = 20;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;    // pos_x, pos_y, pos_z
   logic                    req_tuser = OP_CLAIM;  // opcode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;          // slot, demand
   logic [1:0]              rsp_tuser;          // status

   hash_grid_claim_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Claim table shadow: occupied flags, owning slot per entry, recorded
   // positions per slot, and the frame demand (allocation cursor).
   // ---------------------------------------------------------------------------
   bit             entry_used [TABLE_ENTRIES];
   int unsigned    entry_slot [TABLE_ENTRIES];
   logic [47:0]    slot_pos   [SLOT_CAPACITY];
   logic [15:0]    frame_demand = '0;

   // expected results in order, written at accept, read at the result side
   claim_result_type pending_results [PENDING_DEPTH];
   int               pending_wr = 0;
   int               pending_rd = 0;
   logic [47:0]      key_pool [POOL_DEPTH];
   int               pool_count = 0;

   bit             calm = 1'b0;   // when set, neither side idles
   int             mismatches = 0;
   int             reports = 0;
   int             results_checked = 0;
   int             claims_sent = 0;
   int             clears_sent = 0;
   int             found_seen = 0;
   int             new_seen = 0;
   int             full_seen = 0;
   int             demand_peak = 0;
   int             quiet_cycles = 0;
   claim_result_type got;
   claim_result_type want;

   function automatic logic [31:0] grid_hash(logic [47:0] pos);
      logic [31:0] n;
      // coordinates are sign-extended to 32 bits, all products mod 2^32
      n = ({{16{pos[15]}}, pos[15:0]}  * MUL_X) ^
          ({{16{pos[31]}}, pos[31:16]} * MUL_Y) ^
          ({{16{pos[47]}}, pos[47:32]} * MUL_Z);
      n = n * MIX_MUL + MIX_ADD;
      n = ((n >> ((n >> 28) + 4)) ^ n) * FOLD_MUL;
      n = (n >> 22) ^ n;
      return n;
   endfunction

   // Applies one word to the shadow table and returns the result it must cause.
   function automatic claim_result_type predict_claim(grid_word_type w);
      claim_result_type r;
      int unsigned      idx;
      int               probes;
      int               i;
      bit               settled;
      logic [15:0]      mine;
      r.slot   = '0;
      r.status = ST_FULL;
      if (w.op == OP_CLEAR) begin
         for (i = 0; i < TABLE_ENTRIES; i++) entry_used[i] = 1'b0;
         frame_demand = '0;
         r.status = ST_CLEARED;
         r.demand = '0;
         return r;
      end
      idx = grid_hash(w.pos) & (TABLE_ENTRIES - 1);
      settled = 1'b0;
      for (probes = 0; probes < TABLE_ENTRIES && !settled; probes++) begin
         if (!entry_used[idx]) begin
            // empty entry: take the cursor; it counts even when nothing is granted
            mine = frame_demand;
            if (frame_demand != DEMAND_TOP) frame_demand++;
            if (mine != DEMAND_TOP && mine < SLOT_CAPACITY) begin
               slot_pos[mine]  = w.pos;
               entry_used[idx] = 1'b1;
               entry_slot[idx] = mine;
               r.slot   = mine[7:0];
               r.status = ST_NEW;
            end
            settled = 1'b1;
         end else if (slot_pos[entry_slot[idx]] == w.pos) begin
            r.slot   = entry_slot[idx][7:0];
            r.status = ST_FOUND;
            settled  = 1'b1;
         end
         idx = (idx + 1) & (TABLE_ENTRIES - 1);
      end
      // no match and no empty entry anywhere: same as running out of slots
      if (!settled && frame_demand != DEMAND_TOP) frame_demand++;
      r.demand = frame_demand;
      return r;
   endfunction

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [15:0] rand_coord();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // small signed neighborhood around the origin, -8..8
   function automatic logic [15:0] near_coord();
      logic [15:0] v;
      v = 16'($urandom_range(0, 16));
      return v - 16'd8;
   endfunction

   function automatic logic [15:0] edge_coord();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0001;
         default: return 16'h0000;
      endcase
   endfunction

   // Drives one word from a falling edge, waits for its accept, files the
   // expected result, and returns on the next falling edge. Valid stays high
   // across back-to-back words.
   task automatic put_word(grid_word_type w, bit typed, claim_result_type typed_result);
      int               gap;
      claim_result_type predicted;
      gap = idle_draw();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = w.op;
      req_tdata  = w.pos;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predicted = predict_claim(w);
      pending_results[pending_wr] = typed ? typed_result : predicted;
      pending_wr++;
      if (w.op == OP_CLEAR) begin
         clears_sent++;
      end else begin
         claims_sent++;
         case (predicted.status)
            ST_FOUND: found_seen++;
            ST_NEW:   new_seen++;
            default:  full_seen++;
         endcase
      end
      if (predicted.demand > demand_peak) demand_peak = predicted.demand;
      @(negedge clock);
   endtask

   // random claim: reused keys, grid neighborhoods, extremes and raw noise
   task automatic put_random_claim();
      grid_word_type    w;
      claim_result_type none;
      int               pick;
      none = '0;
      w.op = OP_CLAIM;
      pick = $urandom_range(0, 99);
      if (pick < 40 && pool_count > 0)
         w.pos = key_pool[$urandom_range(0, pool_count - 1)];
      else if (pick < 55)
         w.pos = {near_coord(), near_coord(), near_coord()};
      else if (pick < 65)
         w.pos = {edge_coord(), edge_coord(), edge_coord()};
      else
         w.pos = {rand_coord(), rand_coord(), rand_coord()};
      if (pool_count < POOL_DEPTH) begin
         key_pool[pool_count] = w.pos;
         pool_count++;
      end else begin
         key_pool[$urandom_range(0, POOL_DEPTH - 1)] = w.pos;
      end
      put_word(w, 1'b0, none);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stall a random number of cycles before each word
   // ---------------------------------------------------------------------------
   initial begin : result_ready
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // Result check: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.slot   = rsp_tdata[7:0];
         got.status = status_type'(rsp_tuser);
         got.demand = rsp_tdata[23:8];
         if (pending_wr == pending_rd) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: unexpected result slot %0d status %0d demand %0d",
                        $time, got.slot, rsp_tuser, got.demand);
            end
         end else begin
            want = pending_results[pending_rd];
            pending_rd++;
            results_checked++;
            if (rsp_tdata[7:0] !== want.slot || rsp_tuser !== want.status ||
                rsp_tdata[23:8] !== want.demand) begin
               mismatches++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $display("%0t: exp slot %0d st %0d dem %0d, got slot %0d st %0d dem %0d",
                           $time, want.slot, want.status, want.demand,
                           rsp_tdata[7:0], rsp_tuser, rsp_tdata[23:8]);
               end
            end
         end
      end
   end

   // Watchdog: cycles in a row with no word moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG, pending_wr - pending_rd);
            $display("tb_hash_grid_claim_table: done, errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_MAX];
   int           row_count = 0;

   task automatic add_row(opcode_type op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                          bit typed, logic [7:0] slot, status_type st, logic [15:0] demand);
      stim_row_type row;
      row.word.op       = op;
      row.word.pos      = {z, y, x};
      row.typed         = typed;
      row.result.slot   = slot;
      row.result.status = st;
      row.result.demand = demand;
      directed_rows[row_count] = row;
      row_count++;
   endtask

   initial begin : stimulus
      grid_word_type    w;
      claim_result_type none;
      int               i;
      none = '0;

      // hold reset, then release it; the block then sweeps its entry memory with ready low
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; rows with typed = 0 are answered by the predictor
      //       op         x        y        z        typed slot status      demand
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_NEW,     1);
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_FOUND,   1);
      add_row(OP_CLAIM, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1, ST_NEW,     2);
      add_row(OP_CLAIM, 16'h8000, 16'h8000, 16'h8000, 1, 2, ST_NEW,     3);
      add_row(OP_CLAIM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 3, ST_NEW,     4);
      add_row(OP_CLAIM, 16'h8000, 16'h7FFF, 16'h0000, 1, 4, ST_NEW,     5);
      add_row(OP_CLAIM, 16'h7FFF, 16'h8000, 16'hFFFF, 1, 5, ST_NEW,     6);
      add_row(OP_CLAIM, 16'h8000, 16'h8000, 16'h8000, 1, 2, ST_FOUND,   6);
      add_row(OP_CLAIM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 3, ST_FOUND,   6);
      add_row(OP_CLAIM, 16'h0001, 16'h0000, 16'h0000, 0, 0, ST_NEW,     0);
      add_row(OP_CLAIM, 16'h0000, 16'h0001, 16'h0000, 0, 0, ST_NEW,     0);
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0001, 0, 0, ST_NEW,     0);
      add_row(OP_CLAIM, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, ST_NEW,     0);  // -1 sign-extends
      add_row(OP_CLAIM, 16'h0001, 16'h0000, 16'h0000, 0, 0, ST_NEW,     0);
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_FOUND,   10);
      // clear ignores the position it carries
      add_row(OP_CLEAR, 16'h7FFF, 16'hFFFF, 16'h8000, 1, 0, ST_CLEARED, 0);
      add_row(OP_CLAIM, 16'h8000, 16'h8000, 16'h8000, 1, 0, ST_NEW,     1);
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NEW,     2);
      add_row(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_CLEARED, 0);
      add_row(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_CLEARED, 0);
      add_row(OP_CLAIM, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_NEW,     1);
      for (i = 0; i < row_count; i++)
         put_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

      // random frames: mostly claims, a clear now and then so frames fill and
      // run into capacity full before being emptied
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         if ($urandom_range(0, 499) == 0) begin
            w.op  = OP_CLEAR;
            w.pos = {rand_coord(), rand_coord(), rand_coord()};
            put_word(w, 1'b0, none);
         end else begin
            put_random_claim();
         end
      end

      // fresh frame at the end: clear, then one claim into the empty table
      calm = 1'b0;
      w.op  = OP_CLEAR;
      w.pos = '0;
      put_word(w, 1'b0, none);
      w.op  = OP_CLAIM;
      put_word(w, 1'b0, none);
      req_tvalid = 1'b0;

      while (pending_wr != pending_rd) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d claims (%0d found, %0d newly claimed, %0d full) and %0d clears",
               claims_sent, found_seen, new_seen, full_seen, clears_sent);
      $display("tb: demand peaked at %0d; %0d results checked, %0d mismatches",
               demand_peak, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb_hash_grid_claim_table: done, clean");
      end else begin
         $display("tb_hash_grid_claim_table: done, errors");
      end
      $finish;
   end

endmodule
